### hw/rtl/tsw_pkg.sv
`timescale 1ns / 1ps

package tsw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Fixed field widths.
  localparam int MODE_W = 3;
  localparam int CODE_W = 9;
  localparam int IDX_W  = 11;
  localparam int CUR_W  = 11;
  localparam int DATA_W = 16;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_PUT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SETCUR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HILITE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd4;

  // Special character codes.
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;

  // Cell attributes and fixed cell values.
  localparam logic [7:0]        ATTR_NORMAL = 8'h07;
  localparam logic [7:0]        ATTR_HILITE = 8'h70;
  localparam logic [DATA_W-1:0] BLANK_CELL  = 16'h0720;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    logic [IDX_W-1:0]  range_end;
  } tsw_in_t;

  typedef struct packed {
    logic [CUR_W-1:0]  cursor_pos;
    logic [DATA_W-1:0] cell_data;
    logic              pos_error;
  } tsw_out_t;

  // Kinds of cell sweeps over the screen store.
  typedef enum logic [1:0] {
    SW_CLEAR,
    SW_SCROLL,
    SW_ZERO,
    SW_RANGE
  } tsw_sweep_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_PUT_WR,
    ST_PUT_CHK,
    ST_SWEEP,
    ST_READ,
    ST_READ_CAP,
    ST_BLANK,
    ST_FINISH
  } tsw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       nl_pos;
    logic       put_write;
    logic       set_err;
    logic       sweep_init;
    tsw_sweep_t sweep_kind;
    logic       sweep_run;
    logic       read_cell;
    logic       read_cap;
    logic       blank_write;
    logic       out_load;
  } tsw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              is_nl;
    logic              is_bs;
    logic              idx_ok;
    logic              rng_ok;
    logic              rem_lt_c;
    logic              pos_over;
    logic              need_scroll;
    logic              sweep_done;
    tsw_sweep_t        sweep_kind;
    logic              out_free;
  } tsw_stat_t;

endpackage

### hw/rtl/tsw_ram.sv
`timescale 1ns / 1ps

module tsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tsw_ctrl.sv
`timescale 1ns / 1ps

module tsw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tsw_pkg::tsw_stat_t stat,
  output tsw_pkg::tsw_cmd_t  cmd
);

  import tsw_pkg::*;

  tsw_state_t state_r;
  tsw_state_t state_nxt;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.sweep_kind = SW_CLEAR;
    in_stall       = 1'b1;

    case (state_r)
      ST_INIT: begin
        cmd.sweep_init = 1'b1;
        cmd.sweep_kind = SW_CLEAR;
        state_nxt      = ST_SWEEP;
      end

      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (stat.in_mode)
            MODE_PUT: begin
              if (stat.is_nl) begin
                state_nxt = ST_DIV;
              end else if (stat.is_bs) begin
                state_nxt = ST_PUT_CHK;
              end else begin
                state_nxt = ST_PUT_WR;
              end
            end
            MODE_READ: begin
              state_nxt = stat.idx_ok ? ST_READ : ST_FINISH;
            end
            MODE_HILITE, MODE_NORMAL: begin
              if (stat.rng_ok) begin
                cmd.sweep_init = 1'b1;
                cmd.sweep_kind = SW_RANGE;
                state_nxt      = ST_SWEEP;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      // Column of the cursor by repeated subtraction, for newline.
      ST_DIV: begin
        if (stat.rem_lt_c) begin
          cmd.nl_pos = 1'b1;
          state_nxt  = ST_PUT_CHK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end

      ST_PUT_WR: begin
        cmd.put_write = 1'b1;
        state_nxt     = ST_PUT_CHK;
      end

      ST_PUT_CHK: begin
        if (stat.pos_over) begin
          cmd.set_err = 1'b1;
          state_nxt   = ST_FINISH;
        end else if (stat.need_scroll) begin
          cmd.sweep_init = 1'b1;
          cmd.sweep_kind = SW_SCROLL;
          state_nxt      = ST_SWEEP;
        end else begin
          state_nxt = ST_BLANK;
        end
      end

      // One cell per cycle; the follow-up depends on the sweep kind.
      ST_SWEEP: begin
        if (stat.sweep_done) begin
          case (stat.sweep_kind)
            SW_CLEAR: begin
              state_nxt = ST_IDLE;
            end
            SW_SCROLL: begin
              cmd.sweep_init = 1'b1;
              cmd.sweep_kind = SW_ZERO;
            end
            SW_ZERO: begin
              state_nxt = ST_BLANK;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end else begin
          cmd.sweep_run = 1'b1;
        end
      end

      ST_READ: begin
        cmd.read_cell = 1'b1;
        state_nxt     = ST_READ_CAP;
      end

      ST_READ_CAP: begin
        cmd.read_cap = 1'b1;
        state_nxt    = ST_FINISH;
      end

      ST_BLANK: begin
        cmd.blank_write = 1'b1;
        state_nxt       = ST_FINISH;
      end

      // Wait for the output register to be free, then post the result item.
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

### hw/rtl/tsw_dp.sv
`timescale 1ns / 1ps

module tsw_dp #(
  parameter int COLUMNS = tsw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tsw_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tsw_pkg::tsw_in_t   in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tsw_pkg::tsw_out_t  out_item,
  input  tsw_pkg::tsw_cmd_t  cmd,
  output tsw_pkg::tsw_stat_t stat
);

  import tsw_pkg::*;

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int PW         = $clog2(CELLS + 1);
  localparam int IW         = (PW > IDX_W) ? PW : IDX_W;
  localparam int SCROLL_END = (ROWS - 2) * COLUMNS;
  localparam int LAST_ROW   = (ROWS - 1) * COLUMNS;

  // Control state.
  logic [AW-1:0] cursor_r;
  logic          pend_r;
  logic          out_valid_r;

  // Item and sweep registers.
  logic [7:0]        code_r;
  logic [7:0]        attr_r;
  logic [IW-1:0]     idx_r;
  logic [AW-1:0]     rem_r;
  logic [PW-1:0]     pos_r;
  logic [DATA_W-1:0] data_r;
  logic              err_r;
  tsw_sweep_t        kind_r;
  logic [PW-1:0]     k_r;
  logic [PW-1:0]     limit_r;
  logic [AW-1:0]     wa_r;
  tsw_out_t          out_r;

  // Input decode.
  logic [IW-1:0] idx_ext;
  logic [IW-1:0] rend_ext;
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [IW-1:0] hi_c;
  logic          idx_ok;
  logic          sweep_end;
  logic          issue_rd;

  // Memory port signals.
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  assign idx_ext  = IW'(in_item.cell_index);
  assign rend_ext = IW'(in_item.range_end);
  assign idx_ok   = idx_ext < IW'(CELLS);

  // Range ends in order, upper end clamped to the last cell.
  always_comb begin
    if (idx_ext > rend_ext) begin
      lo = rend_ext;
      hi = idx_ext;
    end else begin
      lo = idx_ext;
      hi = rend_ext;
    end
    hi_c = (hi >= IW'(CELLS)) ? IW'(CELLS - 1) : hi;
  end

  assign sweep_end = k_r >= limit_r;
  assign issue_rd  = cmd.sweep_run && !sweep_end &&
                     (kind_r == SW_SCROLL || kind_r == SW_RANGE);

  // Status toward the controller.
  always_comb begin
    stat.in_mode     = in_item.mode;
    stat.is_nl       = in_item.char_code == CODE_NEWLINE;
    stat.is_bs       = in_item.char_code == CODE_BACKSPACE;
    stat.idx_ok      = idx_ok;
    stat.rng_ok      = lo < IW'(CELLS);
    stat.rem_lt_c    = rem_r < AW'(COLUMNS);
    stat.pos_over    = pos_r > PW'(CELLS);
    stat.need_scroll = pos_r >= PW'(LAST_ROW);
    stat.sweep_done  = sweep_end && !pend_r;
    stat.sweep_kind  = kind_r;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // Memory write port: one source per cycle.
  always_comb begin
    we    = 1'b0;
    waddr = AW'(k_r);
    wdata = '0;
    if (cmd.put_write) begin
      we    = 1'b1;
      waddr = cursor_r;
      wdata = {ATTR_NORMAL, code_r};
    end else if (cmd.blank_write) begin
      we    = 1'b1;
      waddr = AW'(pos_r);
      wdata = BLANK_CELL;
    end else if (pend_r) begin
      we    = 1'b1;
      waddr = wa_r;
      wdata = (kind_r == SW_SCROLL) ? rdata : {attr_r, rdata[7:0]};
    end else if (cmd.sweep_run && !sweep_end) begin
      we = 1'b1;
    end
  end

  // Memory read port: a cell read, or the sweep's source cell.
  always_comb begin
    if (cmd.read_cell) begin
      raddr = AW'(idx_r);
    end else if (kind_r == SW_SCROLL) begin
      raddr = AW'(k_r + PW'(COLUMNS));
    end else begin
      raddr = AW'(k_r);
    end
  end

  tsw_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Cursor, pending sweep write and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && in_item.mode == MODE_SETCUR && idx_ok) begin
        cursor_r <= AW'(idx_ext);
      end else if (cmd.blank_write) begin
        cursor_r <= AW'(pos_r);
      end
      pend_r <= issue_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r <= in_item.char_code[7:0];
      attr_r <= (in_item.mode == MODE_HILITE) ? ATTR_HILITE : ATTR_NORMAL;
      idx_r  <= idx_ext;
      data_r <= '0;
      err_r  <= (in_item.mode == MODE_READ || in_item.mode == MODE_SETCUR) && !idx_ok;
      rem_r  <= cursor_r;
      if (in_item.char_code == CODE_BACKSPACE) begin
        pos_r <= (cursor_r == '0) ? '0 : PW'(cursor_r) - PW'(1);
      end else begin
        pos_r <= PW'(cursor_r) + PW'(1);
      end
    end else begin
      if (cmd.div_step) begin
        rem_r <= rem_r - AW'(COLUMNS);
      end
      if (cmd.nl_pos) begin
        pos_r <= PW'(cursor_r) + PW'(COLUMNS) - PW'(rem_r);
      end
      if (cmd.sweep_init && cmd.sweep_kind == SW_ZERO) begin
        pos_r <= pos_r - PW'(COLUMNS);
      end
      if (cmd.set_err) begin
        err_r <= 1'b1;
      end
      if (cmd.read_cap) begin
        data_r <= rdata;
      end
    end
  end

  // Sweep counter and the target of the pending write.
  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      kind_r <= cmd.sweep_kind;
      case (cmd.sweep_kind)
        SW_CLEAR: begin
          k_r     <= '0;
          limit_r <= PW'(CELLS);
        end
        SW_SCROLL: begin
          k_r     <= '0;
          limit_r <= PW'(SCROLL_END);
        end
        SW_ZERO: begin
          k_r     <= pos_r - PW'(COLUMNS);
          limit_r <= PW'(LAST_ROW);
        end
        default: begin
          k_r     <= PW'(lo);
          limit_r <= PW'(hi_c) + PW'(1);
        end
      endcase
    end else if (cmd.sweep_run && !sweep_end) begin
      k_r <= k_r + PW'(1);
    end
    wa_r <= AW'(k_r);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.cursor_pos <= CUR_W'(cursor_r);
      out_r.cell_data  <= data_r;
      out_r.pos_error  <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### hw/rtl/text_screen_writer_core.sv
`timescale 1ns / 1ps

// Channel   Ports                          Payload
// input     in_valid, in_stall, in_item    tsw_in_t: mode, char_code, cell_index, range_end
// result    out_valid, out_stall, out_item tsw_out_t: cursor_pos, cell_data, pos_error
//
// One item is worked at a time; the next item is taken while a result still waits.
// Put char adds a column search by repeated subtraction for newline, and on a scroll
// a copy of the rows up and a clear of the cells from the new cursor on.
// A range item sweeps over the cells in its range. All sweeps are set by
// the cell store's one write and one read port, one cell per cycle.
// After reset a clearing pass runs before the first item.
// A stalled result holds the block in its last step; inputs wait on in_stall.

module text_screen_writer_core #(
  parameter int COLUMNS = tsw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tsw_pkg::DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tsw_pkg::tsw_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output tsw_pkg::tsw_out_t out_item
);

  import tsw_pkg::*;

  tsw_cmd_t  cmd;
  tsw_stat_t stat;

  tsw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  tsw_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

### verif/tsw_screen_checker.sv
`timescale 1ns / 1ps

module tsw_screen_checker #(
  parameter int COLUMNS = tsw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tsw_pkg::DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  tsw_pkg::tsw_in_t  in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tsw_pkg::tsw_out_t out_item,
  output int                fail_count,
  output int                pending_count
);

  import tsw_pkg::*;

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int MAX_REPORT = 10;

  // Shadow copy of the screen store and cursor.
  logic [DATA_W-1:0] screen_copy [0:CELLS-1];
  int unsigned       cursor_copy;

  // Results predicted for accepted items, oldest first.
  tsw_out_t expected_results [$];
  int       mismatches = 0;

  // Sets the attribute byte over an inclusive range, ends in either order.
  function automatic void paint_range(int unsigned a, int unsigned b, logic [7:0] attr);
    int unsigned lo, hi, p;
    lo = a;
    hi = b;
    if (lo > hi) begin
      lo = b;
      hi = a;
    end
    if (lo >= CELLS) return;
    if (hi >= CELLS) hi = CELLS - 1;
    for (p = lo; p <= hi; p++) screen_copy[p] = {attr, screen_copy[p][7:0]};
  endfunction

  // Puts one character at the cursor and returns the position error flag.
  function automatic logic place_char(logic [CODE_W-1:0] code);
    int unsigned pos, p;
    pos = cursor_copy;
    if (code == CODE_NEWLINE) begin
      pos = pos + COLUMNS - pos % COLUMNS;
    end else if (code == CODE_BACKSPACE) begin
      if (pos > 0) pos--;
    end else begin
      if (pos < CELLS) screen_copy[pos] = {ATTR_NORMAL, code[7:0]};
      pos++;
    end
    if (pos > CELLS) return 1'b1;

    // Reaching the last row scrolls rows up and clears the tail of the
    // second to last row from the new cursor on.
    if (pos / COLUMNS >= ROWS - 1) begin
      for (p = 0; p < (ROWS - 2) * COLUMNS; p++) screen_copy[p] = screen_copy[p + COLUMNS];
      pos = pos - COLUMNS;
      for (p = pos; p < (ROWS - 1) * COLUMNS; p++) screen_copy[p] = '0;
    end
    cursor_copy = pos;
    if (pos < CELLS) screen_copy[pos] = BLANK_CELL;
    return 1'b0;
  endfunction

  // Applies one item to the shadow state and returns its result.
  function automatic tsw_out_t predict_screen_op(tsw_in_t op);
    tsw_out_t res;
    res = '0;
    case (op.mode)
      MODE_PUT: begin
        res.pos_error = place_char(op.char_code);
      end
      MODE_READ: begin
        if (op.cell_index < CELLS) res.cell_data = screen_copy[op.cell_index];
        else res.pos_error = 1'b1;
      end
      MODE_SETCUR: begin
        if (op.cell_index < CELLS) cursor_copy = op.cell_index;
        else res.pos_error = 1'b1;
      end
      MODE_HILITE: paint_range(op.cell_index, op.range_end, ATTR_HILITE);
      MODE_NORMAL: paint_range(op.cell_index, op.range_end, ATTR_NORMAL);
      default: ;
    endcase
    res.cursor_pos = CUR_W'(cursor_copy);
    return res;
  endfunction

  // Watch both channels: compare each result, then predict for each new item.
  always @(posedge clk) begin : watch
    tsw_out_t want;
    int       p;
    if (!rst_n) begin
      for (p = 0; p < CELLS; p++) screen_copy[p] = '0;
      cursor_copy = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("%0t: result with none expected: cursor %0d data %h error %b",
                     $time, out_item.cursor_pos, out_item.cell_data, out_item.pos_error);
        end else begin
          want = expected_results.pop_front();
          if (out_item.cursor_pos !== want.cursor_pos || out_item.cell_data !== want.cell_data ||
              out_item.pos_error !== want.pos_error) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
              $display("%0t: result mismatch: cursor %0d/%0d data %h/%h error %b/%b (exp/got)",
                       $time, want.cursor_pos, out_item.cursor_pos, want.cell_data,
                       out_item.cell_data, want.pos_error, out_item.pos_error);
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_screen_op(in_item));
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

### verif/text_screen_writer_core_tb.sv
`timescale 1ns / 1ps

module text_screen_writer_core_tb;

  import tsw_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS    = DEF_ROWS;
  localparam int CELLS   = COLUMNS * ROWS;

  // The mode field has codes that no operation uses.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
  localparam int PRINT_LO      = 'h20;
  localparam int PRINT_HI      = 'h7E;
  localparam int IDX_MAX       = (1 << IDX_W) - 1;
  localparam int CODE_MAX      = (1 << CODE_W) - 1;
  localparam int RANDOM_ITEMS  = 250;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 50;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tsw_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  tsw_out_t out_item;
  int       fail_count;
  int       pending;

  // Handshake flags between the item source and the result sink.
  bit hold_req = 1'b0;
  bit no_idle  = 1'b0;

  text_screen_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  tsw_screen_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending_count(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard limit on the whole run.
  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result sink: random stalls, a long hold-off on request, none when told.
  initial begin : result_sink
    int roll, n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        n = 1;
      end else begin
        roll = $urandom_range(0, 19);
        if (roll < 9) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 20);
        end else if (roll < 18) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 40);
        end
      end
      repeat (n) @(negedge clk);
    end
  end

  // Offers one item after a random gap and waits until it is taken.
  task automatic send_op(input logic [MODE_W-1:0] m, input int c, input int i, input int e);
    int gap, roll;
    tsw_in_t op;
    op = '{mode: m, char_code: CODE_W'(c), cell_index: IDX_W'(i), range_end: IDX_W'(e)};
    roll = $urandom_range(0, 19);
    if (no_idle || roll < 12) gap = 0;
    else if (roll < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= op;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : item_source
    int roll, sub, span;
    logic [MODE_W-1:0] m;
    int c, i, e, t;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: printable, newline, backspace and the widest code.
    send_op(MODE_PUT, 'h41, 0, 0);
    send_op(MODE_READ, 0, 0, 0);
    send_op(MODE_READ, 0, 1, 0);
    send_op(MODE_PUT, CODE_MAX, IDX_MAX, IDX_MAX);
    send_op(MODE_PUT, int'(CODE_NEWLINE), 0, 0);
    send_op(MODE_PUT, int'(CODE_BACKSPACE), 0, 0);
    // Backspace at the first cell, then indexes off the screen.
    send_op(MODE_SETCUR, 0, 0, 0);
    send_op(MODE_PUT, int'(CODE_BACKSPACE), 0, 0);
    send_op(MODE_SETCUR, 0, IDX_MAX, 0);
    send_op(MODE_READ, 0, IDX_MAX, 0);
    send_op(MODE_READ, 0, CELLS - 1, 0);
    // Scrolls from the last cell, the end of the second to last row and a newline.
    send_op(MODE_SETCUR, 0, CELLS - 1, 0);
    send_op(MODE_PUT, 'h7F, 0, 0);
    send_op(MODE_SETCUR, 0, (ROWS - 1) * COLUMNS - 1, 0);
    send_op(MODE_PUT, 'h5A, 0, 0);
    send_op(MODE_PUT, int'(CODE_NEWLINE), 0, 0);
    send_op(MODE_SETCUR, 0, CELLS - 1, 0);
    send_op(MODE_PUT, int'(CODE_BACKSPACE), 0, 0);
    send_op(MODE_READ, 0, (ROWS - 3) * COLUMNS, 0);
    // Ranges: whole screen, reversed, clamped and fully off the screen.
    send_op(MODE_HILITE, 0, 0, CELLS - 1);
    send_op(MODE_NORMAL, 0, 100, 50);
    send_op(MODE_HILITE, 0, IDX_MAX, 5);
    send_op(MODE_NORMAL, 0, IDX_MAX, CELLS);
    for (int k = MODE_UNUSED_LO; k <= MODE_UNUSED_HI; k++)
      send_op(MODE_W'(k), $urandom, $urandom, $urandom);

    // Let everything drain, then hold the results off while items keep coming.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (20) begin
      if ($urandom_range(0, 1)) send_op(MODE_READ, 0, $urandom_range(0, CELLS - 1), 0);
      else send_op(MODE_SETCUR, 0, $urandom_range(0, CELLS - 1), 0);
    end
    no_idle = 1'b0;

    // Random part: mostly text with cursor moves, reads and short ranges.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 100 && n < 140);
      roll = $urandom_range(0, 99);
      c = $urandom;
      i = $urandom;
      e = $urandom;
      if (roll < 50) begin
        m = MODE_PUT;
        sub = $urandom_range(0, 99);
        if (sub < 68) c = $urandom_range(PRINT_LO, PRINT_HI);
        else if (sub < 80) c = int'(CODE_NEWLINE);
        else if (sub < 88) c = int'(CODE_BACKSPACE);
      end else if (roll < 68) begin
        m = MODE_READ;
        if ($urandom_range(0, 9) != 0) i = $urandom_range(0, CELLS - 1);
      end else if (roll < 76) begin
        m = MODE_SETCUR;
        sub = $urandom_range(0, 9);
        if (sub < 5) i = $urandom_range(0, CELLS - 1);
        else if (sub < 9) i = $urandom_range(CELLS - 2 * COLUMNS, CELLS - 1);
      end else if (roll < 94) begin
        m = (roll % 2) ? MODE_HILITE : MODE_NORMAL;
        if ($urandom_range(0, 9) != 0) begin
          i = $urandom_range(0, CELLS - 1);
          span = $urandom_range(0, 40);
          e = (i + span > IDX_MAX) ? IDX_MAX : i + span;
          if ($urandom_range(0, 1)) begin
            t = i;
            i = e;
            e = t;
          end
        end
      end else begin
        m = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      end
      send_op(m, c, i, e);
    end
    no_idle = 1'b0;

    // Wait for the last results, then let DRAIN_CYCLES pass for anything stray.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
